>>> rtl/wsht_pkg.sv
// Package for the window stack hit test block: codes, the window rectangle
// record and the result record of the hit unit. No dependencies.
package wsht_pkg;

	localparam logic [2:0] KIND_CREATE = 3'd0;
	localparam logic [2:0] KIND_SHOW   = 3'd1;
	localparam logic [2:0] KIND_HIDE   = 3'd2;
	localparam logic [2:0] KIND_RAISE  = 3'd3;
	localparam logic [2:0] KIND_HIT    = 3'd4;

	localparam int         CLOSE_BOX_WIDTH = 44;
	localparam int         COORD_W         = 18;
	localparam logic [7:0] TITLE_RESET     = 8'd32;

	typedef enum logic [1:0] {
		REGION_BODY  = 2'd0,
		REGION_TITLE = 2'd1,
		REGION_CLOSE = 2'd2
	} region_t;

	typedef struct packed {
		logic signed [15:0] left;
		logic signed [15:0] top;
		logic [14:0]        width;
		logic [14:0]        height;
	} rect_t;

	typedef struct packed {
		logic    contains;
		region_t region;
	} hit_res_t;

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_RAISE = 5'b00010,
		ST_RTAIL = 5'b00100,
		ST_SCAN  = 5'b01000,
		ST_FIN   = 5'b10000
	} state_t;

endpackage

>>> rtl/window_stack_hit_test.sv
// Top level of the window stack hit test block: sequencer, stacking order
// memory, visible marks and result register. Depends on wsht_pkg,
// wsht_rect_mem and wsht_hit_unit.
//
// Usage. Items arrive on the in_valid/in_ready channel: create, show, hide,
// raise or hit test. Each item yields exactly one result item on the
// out_valid/out_ready channel. The title bar height is written through the
// cfg_valid/cfg_ready port, which is always ready; write it only while idle.
// The block handles one item at a time. Create, hide, hit test and rejected
// items walk the stack once from the top; show and raise first walk it
// upward to move the window to the top, then walk it from the top. The
// walks are paced by the single read port of the stacking order memory
// and the one hit unit, which see one stack position per cycle.
// Reset empties the table, hides every window and sets the title height to
// 32. When the receiver stalls, the result is held in the output register
// and the next item is still accepted; that item then waits at its end until
// the register frees up.
module window_stack_hit_test #(
	parameter int MAX_WINDOWS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [7:0]         title_height,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [2:0]         kind,
	input  logic [3:0]         window_id,
	input  logic signed [15:0] left,
	input  logic signed [15:0] top,
	input  logic [14:0]        width,
	input  logic [14:0]        height,
	input  logic signed [15:0] point_x,
	input  logic signed [15:0] point_y,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               ok,
	output logic [3:0]         new_window,
	output logic               hit_found,
	output logic [3:0]         hit_window,
	output logic [1:0]         hit_region,
	output logic               focused_found,
	output logic [3:0]         focused_window,
	output logic [4:0]         window_count
);
	import wsht_pkg::*;

	localparam int IW    = $clog2(MAX_WINDOWS);
	localparam int CW    = $clog2(MAX_WINDOWS + 1);
	localparam int CMP_W = (CW > 4) ? CW : 4;
	localparam logic [CW-1:0] MaxCount = CW'(MAX_WINDOWS);

	state_t             state_q;
	logic [CW-1:0]      used_count_q, cnt_q, idx_s1;
	logic [7:0]         title_height_q;
	logic [MAX_WINDOWS-1:0] vis_q;
	logic [IW-1:0]      stack_mem_q [MAX_WINDOWS];
	logic [IW-1:0]      stack_rd_s1, w_s2, id_q;
	logic               s1_valid_q, s2_valid_q, vis_s2;
	logic               found_q, foc_found_q, hit_found_q, is_hit_q, ok_q;
	logic [IW-1:0]      foc_win_q, hit_win_q;
	region_t            hit_region_q;
	logic [3:0]         new_win_q;
	logic signed [15:0] px_q, py_q;

	logic               out_valid_q, ok_out_q, hit_found_out_q, foc_found_out_q;
	logic [3:0]         new_win_out_q, hit_win_out_q, foc_win_out_q;
	logic [1:0]         hit_region_out_q;
	logic [4:0]         count_out_q;

	logic               accept, room, id_ok, acc_ok, go_raise, create_wr, issue, fin_load;
	logic [CW-1:0]      used_next, used_dec, cnt_dec, idx_dec;
	logic               stk_we;
	logic [IW-1:0]      stk_waddr, stk_wdata, stk_raddr;
	rect_t              rect_in, rect_s2;
	hit_res_t           hit_res;

	assign in_ready  = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign accept    = in_valid && in_ready;
	assign room      = used_count_q < MaxCount;
	assign id_ok     = CMP_W'(window_id) < CMP_W'(used_count_q);
	assign used_next = used_count_q + 1'b1;
	assign used_dec  = used_count_q - 1'b1;
	assign cnt_dec   = cnt_q - 1'b1;
	assign idx_dec   = idx_s1 - 1'b1;
	assign create_wr = accept && (kind == KIND_CREATE) && room;
	assign fin_load  = (state_q == ST_FIN) && (!out_valid_q || out_ready);

	// Item decode: which kinds succeed and which need the raise pass.
	always_comb begin
		acc_ok   = 1'b0;
		go_raise = 1'b0;
		unique case (kind)
			KIND_CREATE: acc_ok = room;
			KIND_SHOW, KIND_RAISE: begin
				acc_ok   = id_ok;
				go_raise = id_ok;
			end
			KIND_HIDE:   acc_ok = id_ok;
			KIND_HIT:    acc_ok = 1'b1;
			default:     acc_ok = 1'b0;
		endcase
	end

	// The raise pass walks the stack upward; the scan walks it from the top.
	assign issue = ((state_q == ST_RAISE) && (cnt_q != used_count_q)) ||
	               ((state_q == ST_SCAN) && (cnt_q != '0));
	assign stk_raddr = (state_q == ST_RAISE) ? cnt_q[IW-1:0] : cnt_dec[IW-1:0];

	// Stack write port. During the raise pass, every entry above the raised
	// window slides down one place; the tail step then puts it on top.
	always_comb begin
		stk_we    = 1'b0;
		stk_waddr = '0;
		stk_wdata = '0;
		priority if (create_wr) begin
			stk_we    = 1'b1;
			stk_waddr = used_count_q[IW-1:0];
			stk_wdata = used_count_q[IW-1:0];
		end else if ((state_q == ST_RAISE) && s1_valid_q && found_q) begin
			stk_we    = 1'b1;
			stk_waddr = idx_dec[IW-1:0];
			stk_wdata = stack_rd_s1;
		end else if (state_q == ST_RTAIL) begin
			stk_we    = 1'b1;
			stk_waddr = used_dec[IW-1:0];
			stk_wdata = id_q;
		end else begin
			stk_we    = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (stk_we) begin
			stack_mem_q[stk_waddr] <= stk_wdata;
		end
		stack_rd_s1 <= stack_mem_q[stk_raddr];
		idx_s1      <= cnt_q;
	end

	assign rect_in = '{left: left, top: top, width: width, height: height};

	wsht_rect_mem #(
		.MAX_WINDOWS(MAX_WINDOWS)
	) u_rect_mem (
		.clk    (clk),
		.wr_en  (create_wr),
		.wr_addr(used_count_q[IW-1:0]),
		.wr_data(rect_in),
		.rd_addr(stack_rd_s1),
		.rd_data(rect_s2)
	);

	wsht_hit_unit u_hit_unit (
		.rect   (rect_s2),
		.title_h(title_height_q),
		.px     (px_q),
		.py     (py_q),
		.res    (hit_res)
	);

	// Visible marks live in flip-flops so reset hides every window at once.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vis_q <= '0;
		end else if (accept) begin
			if (create_wr) begin
				vis_q[used_count_q[IW-1:0]] <= 1'b0;
			end else if (id_ok && (kind == KIND_SHOW)) begin
				vis_q[IW'(window_id)] <= 1'b1;
			end else if (id_ok && (kind == KIND_HIDE)) begin
				vis_q[IW'(window_id)] <= 1'b0;
			end
		end
	end

	// Second stage of the scan: window index and its mark, beside the
	// rectangle read from the table.
	always_ff @(posedge clk) begin
		w_s2   <= stack_rd_s1;
		vis_s2 <= vis_q[stack_rd_s1];
	end

	// Sequencer and control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			used_count_q   <= '0;
			cnt_q          <= '0;
			title_height_q <= TITLE_RESET;
			s1_valid_q     <= 1'b0;
			s2_valid_q     <= 1'b0;
			found_q        <= 1'b0;
			foc_found_q    <= 1'b0;
			hit_found_q    <= 1'b0;
			out_valid_q    <= 1'b0;
		end else begin
			if (cfg_valid) begin
				title_height_q <= title_height;
			end
			s1_valid_q <= issue;
			s2_valid_q <= s1_valid_q && (state_q == ST_SCAN);
			if (fin_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						found_q     <= 1'b0;
						foc_found_q <= 1'b0;
						hit_found_q <= 1'b0;
						if (create_wr) begin
							used_count_q <= used_next;
						end
						if (go_raise) begin
							cnt_q   <= '0;
							state_q <= ST_RAISE;
						end else begin
							cnt_q   <= create_wr ? used_next : used_count_q;
							state_q <= ST_SCAN;
						end
					end
				end
				ST_RAISE: begin
					if (issue) begin
						cnt_q <= cnt_q + 1'b1;
					end
					if (s1_valid_q && (stack_rd_s1 == id_q)) begin
						found_q <= 1'b1;
					end
					if (!issue && !s1_valid_q) begin
						state_q <= ST_RTAIL;
					end
				end
				ST_RTAIL: begin
					cnt_q   <= used_count_q;
					state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					if (issue) begin
						cnt_q <= cnt_dec;
					end
					if (s2_valid_q && vis_s2) begin
						foc_found_q <= 1'b1;
						if (is_hit_q && hit_res.contains) begin
							hit_found_q <= 1'b1;
						end
					end
					if (!issue && !s1_valid_q && !s2_valid_q) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (fin_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Item payload and scan results. The first visible window met from the
	// top is the focus; the first visible one holding the point is the hit.
	always_ff @(posedge clk) begin
		if (accept) begin
			id_q         <= IW'(window_id);
			px_q         <= point_x;
			py_q         <= point_y;
			is_hit_q     <= (kind == KIND_HIT);
			ok_q         <= acc_ok;
			new_win_q    <= create_wr ? 4'(used_count_q) : 4'd0;
			foc_win_q    <= '0;
			hit_win_q    <= '0;
			hit_region_q <= REGION_BODY;
		end
		if ((state_q == ST_SCAN) && s2_valid_q && vis_s2) begin
			if (!foc_found_q) begin
				foc_win_q <= w_s2;
			end
			if (is_hit_q && hit_res.contains && !hit_found_q) begin
				hit_win_q    <= w_s2;
				hit_region_q <= hit_res.region;
			end
		end
		if (fin_load) begin
			ok_out_q         <= ok_q;
			new_win_out_q    <= new_win_q;
			hit_found_out_q  <= hit_found_q;
			hit_win_out_q    <= 4'(hit_win_q);
			hit_region_out_q <= hit_region_q;
			foc_found_out_q  <= foc_found_q;
			foc_win_out_q    <= 4'(foc_win_q);
			count_out_q      <= 5'(used_count_q);
		end
	end

	assign out_valid      = out_valid_q;
	assign ok             = ok_out_q;
	assign new_window     = new_win_out_q;
	assign hit_found      = hit_found_out_q;
	assign hit_window     = hit_win_out_q;
	assign hit_region     = hit_region_out_q;
	assign focused_found  = foc_found_out_q;
	assign focused_window = foc_win_out_q;
	assign window_count   = count_out_q;

endmodule

>>> rtl/wsht_hit_unit.sv
// Shared geometry unit: tests one window rectangle against the pointer.
// Depends on wsht_pkg.
module wsht_hit_unit (
	input  wsht_pkg::rect_t     rect,
	input  logic [7:0]          title_h,
	input  logic signed [15:0]  px,
	input  logic signed [15:0]  py,
	output wsht_pkg::hit_res_t  res
);
	import wsht_pkg::*;

	logic signed [COORD_W-1:0] x0, x1, y0, y_title, y_end, x_close, pxe, pye;

	assign x0      = {{(COORD_W-16){rect.left[15]}}, rect.left};
	assign y0      = {{(COORD_W-16){rect.top[15]}}, rect.top};
	assign pxe     = {{(COORD_W-16){px[15]}}, px};
	assign pye     = {{(COORD_W-16){py[15]}}, py};
	assign x1      = x0 + COORD_W'(rect.width);
	assign y_title = y0 + COORD_W'(title_h);
	assign y_end   = y_title + COORD_W'(rect.height);
	assign x_close = x1 - COORD_W'(CLOSE_BOX_WIDTH);

	always_comb begin
		res.contains = (pxe >= x0) && (pxe < x1) && (pye >= y0) && (pye < y_end);
		if (pye < y_title) begin
			res.region = (pxe >= x_close) ? REGION_CLOSE : REGION_TITLE;
		end else begin
			res.region = REGION_BODY;
		end
	end

endmodule

>>> rtl/wsht_rect_mem.sv
// Window rectangle table: one write port, one registered read port.
// Depends on wsht_pkg.
module wsht_rect_mem #(
	parameter int MAX_WINDOWS = 16,
	localparam int IW = $clog2(MAX_WINDOWS)
) (
	input  logic            clk,
	input  logic            wr_en,
	input  logic [IW-1:0]   wr_addr,
	input  wsht_pkg::rect_t wr_data,
	input  logic [IW-1:0]   rd_addr,
	output wsht_pkg::rect_t rd_data
);
	import wsht_pkg::*;

	rect_t rect_mem_q [MAX_WINDOWS];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			rect_mem_q[wr_addr] <= wr_data;
		end
		rd_data <= rect_mem_q[rd_addr];
	end

endmodule

>>> rtl/wsht_chk.sv
// Port-level checker for the window stack hit test block, bound to the top.
// Depends on wsht_pkg and window_stack_hit_test.
module wsht_chk (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic       ok,
	input logic [3:0] new_window,
	input logic       hit_found,
	input logic [3:0] hit_window,
	input logic [1:0] hit_region,
	input logic       focused_found,
	input logic [3:0] focused_window,
	input logic [4:0] window_count
);
	import wsht_pkg::*;

	// One item at a time: the block is busy right after it takes an item.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("in_ready stayed high after an item was accepted");

	// A stalled result holds.
	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(ok) &&
		$stable(new_window) && $stable(hit_window) && $stable(focused_window) &&
		$stable(window_count))
		else $error("stalled result changed");

	a_focus_clear: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !focused_found |-> focused_window == 4'd0)
		else $error("focused_window set without a focused window");

	a_hit_clear: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !hit_found |-> hit_window == 4'd0 && hit_region == REGION_BODY)
		else $error("hit fields set without a hit");

	// A hit window is visible, so something must hold the focus.
	a_hit_needs_focus: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && hit_found |-> focused_found && ok)
		else $error("hit reported without a focused window");

endmodule

bind window_stack_hit_test wsht_chk u_wsht_chk (.*);

>>> tb/window_stack_hit_test_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for window_stack_hit_test: a directed table of items, then phases
// of random items under several title heights. Depends on wsht_pkg and the block's RTL.
module window_stack_hit_test_test;
	import wsht_pkg::*;

	localparam int WINDOWS      = 16;
	localparam int PHASES       = 5;
	localparam int PHASE_ITEMS  = 400;
	localparam int DIR_ROWS     = 27;
	// Idle cycles allowed after the last result before a title height write or the end.
	localparam int SETTLE       = 2 * WINDOWS + 8;
	localparam int HOLD_CYCLES  = 300;
	localparam int CYCLE_LIMIT  = 600000;
	localparam int REPORT_LIMIT = 10;

	// Kinds 5 to 7 have no meaning. The block must refuse them.
	localparam logic [2:0] KIND_SPARE_A = 3'd5;
	localparam logic [2:0] KIND_SPARE_C = 3'd7;

	typedef struct packed {
		logic [2:0]         kind;
		logic [3:0]         window_id;
		logic signed [15:0] left;
		logic signed [15:0] top;
		logic [14:0]        width;
		logic [14:0]        height;
		logic signed [15:0] px;
		logic signed [15:0] py;
	} item_t;

	typedef struct packed {
		logic       ok;
		logic [3:0] new_window;
		logic       hit_found;
		logic [3:0] hit_window;
		region_t    hit_region;
		logic       focused_found;
		logic [3:0] focused_window;
		logic [4:0] window_count;
	} outcome_t;

	// One row of the directed table. When typed is set, want holds a value written by hand.
	// Otherwise the row is checked against the predictor.
	typedef struct {
		item_t    it;
		bit       typed;
		outcome_t want;
	} row_t;

	logic clk;
	logic arst_n;
	logic cfg_valid;
	logic cfg_ready;
	logic [7:0] cfg_val;
	logic in_valid;
	logic in_ready;
	item_t offer;
	bit offer_typed;
	outcome_t offer_want;
	logic out_valid;
	logic out_ready;
	logic ok;
	logic [3:0] new_window;
	logic hit_found;
	logic [3:0] hit_window;
	logic [1:0] hit_region;
	logic focused_found;
	logic [3:0] focused_window;
	logic [4:0] window_count;

	// The testbench's own copy of the window table, the stack and the title height.
	logic signed [15:0] win_left [WINDOWS];
	logic signed [15:0] win_top [WINDOWS];
	logic [14:0] win_w [WINDOWS];
	logic [14:0] win_h [WINDOWS];
	logic shown [WINDOWS];
	logic [3:0] z_order [WINDOWS];
	int unsigned n_windows;
	logic [7:0] bar_h;

	outcome_t pending_outcomes [$];
	row_t plan [DIR_ROWS];
	logic [7:0] phase_title [PHASES];

	int errors;
	int items_taken;
	int results_checked;
	int hits_landed;
	int refused;
	bit steady;
	bit stall_request;
	bit stall_done;
	int cycles;

	window_stack_hit_test #(
		.MAX_WINDOWS(WINDOWS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.title_height(cfg_val),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.kind(offer.kind),
		.window_id(offer.window_id),
		.left(offer.left),
		.top(offer.top),
		.width(offer.width),
		.height(offer.height),
		.point_x(offer.px),
		.point_y(offer.py),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.ok(ok),
		.new_window(new_window),
		.hit_found(hit_found),
		.hit_window(hit_window),
		.hit_region(hit_region),
		.focused_found(focused_found),
		.focused_window(focused_window),
		.window_count(window_count)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Applies one item to the testbench's window table and returns the result that the block
	// must give for it. Focus and count are taken after the item has been applied.
	function automatic outcome_t apply_window_op(item_t it);
		outcome_t res;
		int i;
		int pos;
		int unsigned w;
		int x0, y0, x1, wd, ht, th, px, py;
		res = '0;
		res.hit_region = REGION_BODY;
		case (it.kind)
			KIND_CREATE: begin
				if (n_windows < WINDOWS) begin
					win_left[n_windows] = it.left;
					win_top[n_windows] = it.top;
					win_w[n_windows] = it.width;
					win_h[n_windows] = it.height;
					shown[n_windows] = 1'b0;
					z_order[n_windows] = 4'(n_windows);
					res.ok = 1'b1;
					res.new_window = 4'(n_windows);
					n_windows++;
				end
			end
			KIND_SHOW, KIND_HIDE, KIND_RAISE: begin
				if (it.window_id < n_windows) begin
					res.ok = 1'b1;
					if (it.kind == KIND_SHOW)
						shown[it.window_id] = 1'b1;
					else if (it.kind == KIND_HIDE)
						shown[it.window_id] = 1'b0;
					// Show and raise both pull the window out of the stack and put it on top.
					if (it.kind != KIND_HIDE) begin
						pos = -1;
						for (i = 0; i < n_windows; i++) begin
							if (pos < 0 && z_order[i] == it.window_id)
								pos = i;
						end
						if (pos >= 0) begin
							for (i = pos; i + 1 < n_windows; i++)
								z_order[i] = z_order[i + 1];
							z_order[n_windows - 1] = it.window_id;
						end
					end
				end
			end
			KIND_HIT: begin
				res.ok = 1'b1;
				px = it.px;
				py = it.py;
				th = bar_h;
				for (i = int'(n_windows) - 1; i >= 0 && !res.hit_found; i--) begin
					w = z_order[i];
					x0 = win_left[w];
					y0 = win_top[w];
					wd = win_w[w];
					ht = win_h[w];
					x1 = x0 + wd;
					if (shown[w] && px >= x0 && px < x1 && py >= y0 && py < y0 + ht + th) begin
						res.hit_found = 1'b1;
						res.hit_window = 4'(w);
						if (py >= y0 + th)
							res.hit_region = REGION_BODY;
						else if (px >= x1 - CLOSE_BOX_WIDTH)
							res.hit_region = REGION_CLOSE;
						else
							res.hit_region = REGION_TITLE;
					end
				end
			end
			default: begin
			end
		endcase
		for (i = int'(n_windows) - 1; i >= 0 && !res.focused_found; i--) begin
			if (shown[z_order[i]]) begin
				res.focused_found = 1'b1;
				res.focused_window = z_order[i];
			end
		end
		res.window_count = 5'(n_windows);
		return res;
	endfunction

	function automatic item_t mk_item(logic [2:0] k, int id, int l, int t, int w, int h,
			int x, int y);
		item_t it;
		it.kind = k;
		it.window_id = 4'(id);
		it.left = 16'(l);
		it.top = 16'(t);
		it.width = 15'(w);
		it.height = 15'(h);
		it.px = 16'(x);
		it.py = 16'(y);
		return it;
	endfunction

	function automatic outcome_t mk_res(bit okv, int nw, bit hf, int hw, region_t rg, bit ff,
			int fw, int cnt);
		outcome_t res;
		res.ok = okv;
		res.new_window = 4'(nw);
		res.hit_found = hf;
		res.hit_window = 4'(hw);
		res.hit_region = rg;
		res.focused_found = ff;
		res.focused_window = 4'(fw);
		res.window_count = 5'(cnt);
		return res;
	endfunction

	function automatic logic signed [15:0] clamp16(int v);
		if (v > 32767)
			return 16'sh7fff;
		if (v < -32768)
			return 16'sh8000;
		return 16'(v);
	endfunction

	// Random item. Most items are well formed: ids of existing windows, windows placed in a
	// small area so that they overlap, and points aimed at or just around a chosen window,
	// with a share aimed at the edge of the close box. The rest is noise over the full fields.
	function automatic item_t pick_item();
		item_t it;
		int r, x0, y0, wd, ht, th, px, py;
		int unsigned w;
		it.kind = KIND_HIT;
		it.window_id = 4'($urandom);
		it.left = 16'($urandom);
		it.top = 16'($urandom);
		it.width = 15'($urandom);
		it.height = 15'($urandom);
		it.px = 16'($urandom);
		it.py = 16'($urandom);
		r = $urandom_range(0, 99);
		if (r < 12) begin
			it.kind = KIND_CREATE;
			if ($urandom_range(0, 99) < 85) begin
				it.left = 16'(int'($urandom_range(0, 600)) - 300);
				it.top = 16'(int'($urandom_range(0, 600)) - 300);
				if ($urandom_range(0, 9) < 3)
					it.width = 15'($urandom_range(0, 60));
				else
					it.width = 15'($urandom_range(0, 300));
				it.height = 15'($urandom_range(0, 200));
			end
		end else if (r < 62) begin
			if (r < 34)
				it.kind = KIND_SHOW;
			else if (r < 48)
				it.kind = KIND_HIDE;
			else
				it.kind = KIND_RAISE;
			if (n_windows > 0 && $urandom_range(0, 99) < 85)
				it.window_id = 4'($urandom_range(0, n_windows - 1));
		end else if (r < 95) begin
			if (n_windows > 0 && $urandom_range(0, 99) < 85) begin
				w = $urandom_range(0, n_windows - 1);
				x0 = win_left[w];
				y0 = win_top[w];
				wd = win_w[w];
				ht = win_h[w];
				th = bar_h;
				if ($urandom_range(0, 3) == 0) begin
					px = x0 + wd - CLOSE_BOX_WIDTH - 1 + int'($urandom_range(0, 2));
					py = y0 - 1 + int'($urandom_range(0, th + 1));
				end else begin
					px = x0 - 4 + int'($urandom_range(0, wd + 8));
					py = y0 - 4 + int'($urandom_range(0, th + ht + 8));
				end
				it.px = clamp16(px);
				it.py = clamp16(py);
			end
		end else begin
			it.kind = 3'($urandom_range(KIND_SPARE_A, KIND_SPARE_C));
		end
		return it;
	endfunction

	// Offers one item and returns once it has been accepted. Outside the steady phase the
	// sender sometimes drops valid for a random stretch, so gaps land at every point of the
	// block's walk over the stack.
	task automatic send_item(item_t it, bit typed, outcome_t want);
		@(negedge clk);
		if (!steady && $urandom_range(0, 99) < 8) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 40)) @(negedge clk);
		end
		offer <= it;
		offer_typed <= typed;
		offer_want <= want;
		in_valid <= 1'b1;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	// Stops offering items, waits until every result is in and the block has settled.
	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_outcomes.size() != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	// The title height is only written while the block is idle.
	task automatic write_title(logic [7:0] value);
		drain();
		cfg_valid <= 1'b1;
		cfg_val <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Predicts at every accepted item and checks every accepted result against the oldest
	// prediction. The title height copy follows the configuration handshake.
	always @(posedge clk) begin : watch
		outcome_t want;
		outcome_t got;
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				bar_h = cfg_val;
			if (in_valid && in_ready) begin
				want = apply_window_op(offer);
				if (offer_typed)
					want = offer_want;
				pending_outcomes.push_back(want);
				items_taken++;
			end
			if (out_valid && out_ready) begin
				got.ok = ok;
				got.new_window = new_window;
				got.hit_found = hit_found;
				got.hit_window = hit_window;
				got.hit_region = region_t'(hit_region);
				got.focused_found = focused_found;
				got.focused_window = focused_window;
				got.window_count = window_count;
				if (pending_outcomes.size() == 0) begin
					errors++;
					if (errors <= REPORT_LIMIT)
						$display("Result %0d arrived with no item waiting for it", results_checked);
				end else begin
					want = pending_outcomes.pop_front();
					if (got !== want) begin
						errors++;
						if (errors <= REPORT_LIMIT)
							$display({"Result %0d differs: expected ok=%0d new=%0d hit=%0d win=%0d",
								" region=%0d focus=%0d/%0d count=%0d, got ok=%0d new=%0d hit=%0d",
								" win=%0d region=%0d focus=%0d/%0d count=%0d"}, results_checked,
								want.ok, want.new_window, want.hit_found, want.hit_window,
								want.hit_region, want.focused_found, want.focused_window,
								want.window_count, got.ok, got.new_window, got.hit_found,
								got.hit_window, got.hit_region, got.focused_found,
								got.focused_window, got.window_count);
					end
					if (want.hit_found)
						hits_landed++;
					if (!want.ok)
						refused++;
				end
				results_checked++;
			end
		end
	end

	// Receiver. It stalls at random, with a chance of 8 in a hundred, never in the steady phase, and once
	// holds off for a long stretch so that the block fills up and stops taking items.
	initial begin
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (stall_request && !stall_done) begin
				stall_done = 1'b1;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				out_ready <= 1'b1;
			end else begin
				out_ready <= steady || ($urandom_range(0, 99) >= 8);
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Run did not finish within %0d cycles", CYCLE_LIMIT);
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin : stimulus
		int k;
		int ph;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_val = 8'd0;
		in_valid = 1'b0;
		offer = '0;
		offer_typed = 1'b0;
		offer_want = '0;
		steady = 1'b0;
		stall_request = 1'b0;
		stall_done = 1'b0;
		errors = 0;
		items_taken = 0;
		results_checked = 0;
		hits_landed = 0;
		refused = 0;
		cycles = 0;
		n_windows = 0;
		bar_h = TITLE_RESET;
		for (k = 0; k < WINDOWS; k++)
			shown[k] = 1'b0;

		// Directed table, run under the reset title height of 32. Window 0 spans the whole
		// negative quarter of the plane, window 1 has no area at the far corner, and window 2
		// is narrower than the close box, so its whole title bar is close box.
		plan[0] = '{mk_item(KIND_HIT, 0, 0, 0, 0, 0, 0, 0), 1'b1,
			mk_res(1, 0, 0, 0, REGION_BODY, 0, 0, 0)};
		plan[1] = '{mk_item(KIND_SHOW, 0, 0, 0, 0, 0, 0, 0), 1'b1,
			mk_res(0, 0, 0, 0, REGION_BODY, 0, 0, 0)};
		plan[2] = '{mk_item(KIND_SPARE_A, 0, 0, 0, 0, 0, 0, 0), 1'b1,
			mk_res(0, 0, 0, 0, REGION_BODY, 0, 0, 0)};
		plan[3] = '{mk_item(KIND_CREATE, 0, -32768, -32768, 32767, 32767, 0, 0), 1'b1,
			mk_res(1, 0, 0, 0, REGION_BODY, 0, 0, 1)};
		plan[4] = '{mk_item(KIND_HIT, 0, 0, 0, 0, 0, 0, 0), 1'b1,
			mk_res(1, 0, 0, 0, REGION_BODY, 0, 0, 1)};
		plan[5] = '{mk_item(KIND_SHOW, 0, 0, 0, 0, 0, 0, 0), 1'b1,
			mk_res(1, 0, 0, 0, REGION_BODY, 1, 0, 1)};
		plan[6] = '{mk_item(KIND_HIT, 0, 0, 0, 0, 0, -32768, -32768), 1'b1,
			mk_res(1, 0, 1, 0, REGION_TITLE, 1, 0, 1)};
		plan[7] = '{mk_item(KIND_HIT, 0, 0, 0, 0, 0, 32767, 32767), 1'b1,
			mk_res(1, 0, 0, 0, REGION_BODY, 1, 0, 1)};
		plan[8] = '{mk_item(KIND_HIT, 0, 0, 0, 0, 0, -2, 0), 1'b1,
			mk_res(1, 0, 1, 0, REGION_BODY, 1, 0, 1)};
		plan[9] = '{mk_item(KIND_HIT, 0, 0, 0, 0, 0, -45, -32737), 1'b1,
			mk_res(1, 0, 1, 0, REGION_CLOSE, 1, 0, 1)};
		plan[10] = '{mk_item(KIND_CREATE, 0, 32767, 32767, 0, 0, 0, 0), 1'b1,
			mk_res(1, 1, 0, 0, REGION_BODY, 1, 0, 2)};
		plan[11] = '{mk_item(KIND_SHOW, 1, 0, 0, 0, 0, 0, 0), 1'b1,
			mk_res(1, 0, 0, 0, REGION_BODY, 1, 1, 2)};
		plan[12] = '{mk_item(KIND_HIT, 0, 0, 0, 0, 0, 32767, 32767), 1'b0, '0};
		plan[13] = '{mk_item(KIND_CREATE, 0, 100, 100, 40, 50, 0, 0), 1'b0, '0};
		plan[14] = '{mk_item(KIND_SHOW, 2, 0, 0, 0, 0, 0, 0), 1'b0, '0};
		plan[15] = '{mk_item(KIND_HIT, 0, 0, 0, 0, 0, 100, 100), 1'b0, '0};
		plan[16] = '{mk_item(KIND_HIT, 0, 0, 0, 0, 0, 139, 131), 1'b0, '0};
		plan[17] = '{mk_item(KIND_HIT, 0, 0, 0, 0, 0, 139, 132), 1'b0, '0};
		plan[18] = '{mk_item(KIND_HIT, 0, 0, 0, 0, 0, 140, 132), 1'b0, '0};
		plan[19] = '{mk_item(KIND_HIDE, 1, 0, 0, 0, 0, 0, 0), 1'b0, '0};
		plan[20] = '{mk_item(KIND_RAISE, 0, 0, 0, 0, 0, 0, 0), 1'b0, '0};
		plan[21] = '{mk_item(KIND_HIDE, 0, 0, 0, 0, 0, 0, 0), 1'b0, '0};
		plan[22] = '{mk_item(KIND_RAISE, 5, 0, 0, 0, 0, 0, 0), 1'b0, '0};
		plan[23] = '{mk_item(KIND_HIDE, 3, 0, 0, 0, 0, 0, 0), 1'b0, '0};
		plan[24] = '{mk_item(KIND_SPARE_C, 15, -1, -1, 32767, 32767, -1, -1), 1'b0, '0};
		plan[25] = '{mk_item(KIND_HIT, 0, 0, 0, 0, 0, 120, 181), 1'b0, '0};
		plan[26] = '{mk_item(KIND_HIT, 0, 0, 0, 0, 0, 120, 182), 1'b0, '0};

		// Title heights of the random phases: both extremes, a thin bar, a random one and one
		// as tall as the close box is wide.
		phase_title[0] = 8'd255;
		phase_title[1] = 8'd0;
		phase_title[2] = 8'd7;
		phase_title[3] = 8'($urandom_range(1, 254));
		phase_title[4] = 8'(CLOSE_BOX_WIDTH);

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (k = 0; k < DIR_ROWS; k++)
			send_item(plan[k].it, plan[k].typed, plan[k].want);

		// The table fills up early in the first phase. From then on creates are refused and
		// the run works on a full stack. The third phase runs with no idling on either side.
		for (ph = 0; ph < PHASES; ph++) begin
			write_title(phase_title[ph]);
			steady = (ph == 2);
			for (k = 0; k < PHASE_ITEMS; k++) begin
				if (ph == 1 && k == 60)
					stall_request = 1'b1;
				send_item(pick_item(), 1'b0, '0);
			end
		end
		drain();

		$display("Checked %0d results for %0d items: %0d landed on a window, %0d were refused.",
			results_checked, items_taken, hits_landed, refused);
		$display("Title heights used: 32, 255, 0, 7, %0d and %0d; %0d windows at the end.",
			phase_title[3], phase_title[4], n_windows);
		if (errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
